>>> sv/ucs2u8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs2u8_pkg: shared types and constants of the UCS-2 to UTF-8 encoder
// Item layouts, the per-unit job record passed from front to back, register
// indexes and the UTF-8 lead and continuation byte patterns.
// ----------------------------------------------------------------------------
package ucs2u8_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned CountW = 20;
  localparam int unsigned CapW   = 16;
  localparam int unsigned CfgW   = 16;

  localparam logic [CountW-1:0] CountMax = 20'hFFFFF;

  localparam logic [UnitW-1:0] OneByteLimit = 16'h0080;
  localparam logic [UnitW-1:0] TwoByteLimit = 16'h0800;

  localparam logic [7:0] Lead2Byte = 8'hC0;
  localparam logic [7:0] Lead3Byte = 8'hE0;
  localparam logic [7:0] ContByte  = 8'h80;

  typedef enum logic [0:0] {
    REG_DEST_CAPACITY = 1'b0,
    REG_STRING_MODE   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             begin_req;
    logic             last_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              is_terminator;
    logic              last_of_run;
    logic              halted;
    logic [CountW-1:0] byte_count;
  } out_item_t;

  // Everything the back end needs to produce the results of one code unit.
  typedef struct packed {
    logic [2:0][7:0]   enc_bytes;
    logic [1:0]        n_bytes;
    logic              term;
    logic              halted;
    logic [CountW-1:0] byte_count;
  } job_t;

endpackage

>>> sv/ucs2u8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs2u8_front: input side of the encoder
// Holds the configuration registers and the conversion state, classifies each
// accepted code unit and turns it into one job record for the back end.
// ----------------------------------------------------------------------------
module ucs2u8_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  ucs2u8_pkg::cfg_reg_e        cfg_idx_i,
  input  logic [ucs2u8_pkg::CfgW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  input  ucs2u8_pkg::in_item_t        in_item_i,
  input  logic                        job_ready_i,
  output logic                        job_push_o,
  output ucs2u8_pkg::job_t            job_o
);

  logic [ucs2u8_pkg::CapW-1:0]   cap_q;
  logic                          str_cfg_q;
  logic                          meas_q, meas_d;
  logic                          str_q, str_d;
  logic [ucs2u8_pkg::CapW-1:0]   space_q, space_d;
  logic [ucs2u8_pkg::CountW-1:0] count_q, count_d;
  logic                          done_q, done_d;

  logic [ucs2u8_pkg::CapW-1:0]   space_eff;
  logic [ucs2u8_pkg::CountW-1:0] count_eff;
  logic                          done_eff;
  logic [1:0]                    n_len;
  logic [ucs2u8_pkg::CountW:0]   count_sum;
  logic [ucs2u8_pkg::UnitW-1:0]  unit;
  logic                          finish;
  logic                          term;
  logic [1:0]                    n_emit;

  assign unit       = in_item_i.code_unit;
  assign job_push_o = in_valid_i && job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= '0;
      str_cfg_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ucs2u8_pkg::REG_DEST_CAPACITY: cap_q     <= cfg_data_i;
        ucs2u8_pkg::REG_STRING_MODE:   str_cfg_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Start of a new conversion latches the configuration first.
    if (in_item_i.begin_req) begin
      meas_d    = (cap_q == '0);
      str_d     = str_cfg_q;
      space_eff = (cap_q == '0) ? '0 :
                  (str_cfg_q ? cap_q - ucs2u8_pkg::CapW'(1) : cap_q);
      count_eff = str_cfg_q ? ucs2u8_pkg::CountW'(1) : '0;
      done_eff  = 1'b0;
    end else begin
      meas_d    = meas_q;
      str_d     = str_q;
      space_eff = space_q;
      count_eff = count_q;
      done_eff  = done_q;
    end

    if (unit < ucs2u8_pkg::OneByteLimit) begin
      n_len = 2'd1;
    end else if (unit < ucs2u8_pkg::TwoByteLimit) begin
      n_len = 2'd2;
    end else begin
      n_len = 2'd3;
    end

    count_sum = {1'b0, count_eff} + (ucs2u8_pkg::CountW + 1)'(n_len);

    finish  = 1'b0;
    term    = 1'b0;
    n_emit  = 2'd0;
    space_d = space_eff;
    count_d = count_eff;

    if (!done_eff) begin
      if (str_d && unit == '0) begin
        finish = 1'b1;
        term   = !meas_d;
      end else if (!meas_d && space_eff < ucs2u8_pkg::CapW'(n_len)) begin
        finish = 1'b1;
        term   = str_d || (space_eff != '0);
      end else begin
        if (!meas_d) begin
          n_emit  = n_len;
          space_d = space_eff - ucs2u8_pkg::CapW'(n_len);
        end
        count_d = count_sum[ucs2u8_pkg::CountW] ? ucs2u8_pkg::CountMax
                                                : count_sum[ucs2u8_pkg::CountW-1:0];
        if (in_item_i.last_unit && !str_d) begin
          finish = 1'b1;
          term   = !meas_d && (space_d != '0);
        end
      end
    end
    done_d = done_eff || finish;

    job_o.n_bytes    = n_emit;
    job_o.term       = term;
    job_o.halted     = done_d;
    job_o.byte_count = count_d;
    unique case (n_len)
      2'd1: begin
        job_o.enc_bytes[0] = unit[7:0];
        job_o.enc_bytes[1] = '0;
        job_o.enc_bytes[2] = '0;
      end
      2'd2: begin
        job_o.enc_bytes[0] = ucs2u8_pkg::Lead2Byte | {3'b0, unit[10:6]};
        job_o.enc_bytes[1] = ucs2u8_pkg::ContByte | {2'b0, unit[5:0]};
        job_o.enc_bytes[2] = '0;
      end
      default: begin
        job_o.enc_bytes[0] = ucs2u8_pkg::Lead3Byte | {4'b0, unit[15:12]};
        job_o.enc_bytes[1] = ucs2u8_pkg::ContByte | {2'b0, unit[11:6]};
        job_o.enc_bytes[2] = ucs2u8_pkg::ContByte | {2'b0, unit[5:0]};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_q  <= 1'b1;
      str_q   <= 1'b0;
      space_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else if (job_push_o) begin
      meas_q  <= meas_d;
      str_q   <= str_d;
      space_q <= space_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

endmodule

>>> sv/ucs2u8_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs2u8_queue: job queue between front and back
// A small first-in first-out buffer of job records so that each side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module ucs2u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ucs2u8_pkg::job_t push_data_i,
  output logic             not_full_o,
  input  logic             pop_i,
  output logic             not_empty_o,
  output ucs2u8_pkg::job_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ucs2u8_pkg::job_t entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign not_full_o  = (cnt_q != CntW'(DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cnt_q <= CntW'(DEPTH))
    else $error("queue fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");

endmodule

>>> sv/ucs2u8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs2u8_back: output side of the encoder
// Walks through the head job one result per cycle while the output is taken (encoded bytes, then the
// terminator, or a single empty result) into the output register.
// ----------------------------------------------------------------------------
module ucs2u8_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  ucs2u8_pkg::job_t      job_i,
  output logic                  job_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ucs2u8_pkg::out_item_t out_item_o
);

  logic [1:0]            idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  ucs2u8_pkg::out_item_t out_q, out_d;
  logic [2:0]            total;
  logic                  is_last;
  logic                  load;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    total = 3'(job_i.n_bytes) + 3'(job_i.term);
    if (total == '0) begin
      total = 3'd1;
    end
    is_last = (3'(idx_q) == total - 3'd1);
    load    = job_valid_i && (!out_valid_q || out_ready_i);

    out_d.halted      = job_i.halted;
    out_d.byte_count  = job_i.byte_count;
    out_d.last_of_run = is_last;
    if (idx_q < job_i.n_bytes) begin
      out_d.out_byte      = job_i.enc_bytes[idx_q];
      out_d.byte_valid    = 1'b1;
      out_d.is_terminator = 1'b0;
    end else begin
      out_d.out_byte      = '0;
      out_d.byte_valid    = job_i.term;
      out_d.is_terminator = job_i.term;
    end

    job_pop_o = load && is_last;
    idx_d     = idx_q;
    if (load) begin
      idx_d = is_last ? '0 : idx_q + 2'd1;
    end
    out_valid_d = load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

>>> sv/ucs2_to_utf8_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs2_to_utf8_encoder_top: streaming UCS-2 to UTF-8 encoder
// With the queue empty, an accepted item is first written into the job queue,
// and its first result is then loaded from there into the output register.
// Throughput: one result per cycle while the receiver takes them; an item gives
// 1 to 4 results (its UTF-8 bytes plus an optional terminator), as the output register is byte-wide.
// The front accepts one item per cycle while the job queue has room.
// Reset clears the conversion state to measure-only, non-string mode.
// ----------------------------------------------------------------------------
module ucs2_to_utf8_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration writes: index 0 is the capacity, index 1 string mode.
  input  logic                        cfg_we_i,
  input  ucs2u8_pkg::cfg_reg_e        cfg_idx_i,
  input  logic [ucs2u8_pkg::CfgW-1:0] cfg_data_i,
  // Code unit items in.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ucs2u8_pkg::in_item_t        in_item_i,
  // Result items out.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ucs2u8_pkg::out_item_t       out_item_o
);

  // Front to queue: each accepted item becomes exactly one job record, which
  // already carries the final count and halt flag of that item.
  logic             job_push;
  ucs2u8_pkg::job_t job_in;
  logic             q_not_full;

  // Queue to back: the back end pops a job once its last result is loaded.
  logic             q_not_empty;
  ucs2u8_pkg::job_t job_head;
  logic             job_pop;

  assign in_ready_o = q_not_full;

  ucs2u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .job_ready_i (q_not_full),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  ucs2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .not_full_o  (q_not_full),
    .pop_i       (job_pop),
    .not_empty_o (q_not_empty),
    .head_o      (job_head)
  );

  // The back end owns the output register, so a stalled result blocks the front
  // from accepting further items only once the job queue is full.
  ucs2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_not_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // A terminator is always a written zero byte and closes its item's results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && out_item_o.is_terminator |->
                   out_item_o.byte_valid && out_item_o.last_of_run &&
                   out_item_o.out_byte == 8'h00)
    else $error("terminator result malformed");

  // Only real encoded bytes may be followed by further results of one item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && !out_item_o.last_of_run |->
                   out_item_o.byte_valid && !out_item_o.is_terminator)
    else $error("non-final result is not an encoded byte");

  // A result that is not last is followed by another result once taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && out_ready_i && !out_item_o.last_of_run |=>
                   out_valid_o)
    else $error("gap inside the results of one item");

endmodule
